// ===== src/rmq_pkg.sv =====
// Shared constants, types and axis helper for the rotation matrix to quaternion core.
package rmq_pkg;

    localparam int IN_W  = 16;
    localparam int NUM_W = IN_W + 1;
    localparam int Q_W   = 16;

    localparam logic signed [Q_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [Q_W-1:0] Q_MIN = -16'sh8000;

    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef struct packed {
        logic           deg;
        logic [Q_W-1:0] val;
    } comp_t;

    function automatic axis_t next_axis(input axis_t a);
        axis_t r;
        case (a)
            AXIS_X:  r = AXIS_Y;
            AXIS_Y:  r = AXIS_Z;
            default: r = AXIS_X;
        endcase
        return r;
    endfunction

endpackage

// ===== src/rmq_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root.
module rmq_sqrt_cell
    import rmq_pkg::*;
#(
    parameter int SW   = 34,
    parameter int RW   = 17,
    parameter int SIDE = 55
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_i,
    input  logic [SW-1:0]   rad_i,
    input  logic [RW+1:0]   rem_i,
    input  logic [RW-1:0]   root_i,
    input  logic [SIDE-1:0] side_i,
    output logic            vld_o,
    output logic [SW-1:0]   rad_o,
    output logic [RW+1:0]   rem_o,
    output logic [RW-1:0]   root_o,
    output logic [SIDE-1:0] side_o
);

    logic            vld_reg;
    logic [SW-1:0]   rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [SIDE-1:0] side_reg;

    logic [RW+3:0] rem_wide;
    logic [RW+3:0] trial;
    logic          ge;
    logic [RW+3:0] diff;
    logic [RW+1:0] rem_next;
    logic [RW-1:0] root_next;

    always_comb
    begin
        rem_wide  = {rem_i, rad_i[SW-1:SW-2]};
        trial     = {2'b00, root_i, 2'b01};
        ge        = rem_wide >= trial;
        diff      = rem_wide - trial;
        rem_next  = ge ? diff[RW+1:0] : rem_wide[RW+1:0];
        root_next = {root_i[RW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_i[SW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_i;
        end
    end

    assign vld_o  = vld_reg;
    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign side_o = side_reg;

endmodule

// ===== src/rmq_div_cell.sv =====
// One quotient-bit cell of the pipelined restoring divider.
module rmq_div_cell
    import rmq_pkg::*;
#(
    parameter int DW   = 33,
    parameter int DENW = 19,
    parameter int SIDE = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_i,
    input  logic [DW-1:0]   dvd_i,
    input  logic [DENW-1:0] den_i,
    input  logic [DENW-1:0] rem_i,
    input  logic [DW-1:0]   quo_i,
    input  logic [SIDE-1:0] side_i,
    output logic            vld_o,
    output logic [DW-1:0]   dvd_o,
    output logic [DENW-1:0] den_o,
    output logic [DENW-1:0] rem_o,
    output logic [DW-1:0]   quo_o,
    output logic [SIDE-1:0] side_o
);

    logic            vld_reg;
    logic [DW-1:0]   dvd_reg;
    logic [DENW-1:0] den_reg;
    logic [DENW-1:0] rem_reg;
    logic [DW-1:0]   quo_reg;
    logic [SIDE-1:0] side_reg;

    logic [DENW:0]   r2;
    logic [DENW:0]   diff;
    logic            ge;
    logic [DENW-1:0] rem_next;

    always_comb
    begin
        r2       = {rem_i, dvd_i[DW-1]};
        ge       = r2 >= {1'b0, den_i};
        diff     = r2 - {1'b0, den_i};
        rem_next = ge ? diff[DENW-1:0] : r2[DENW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg  <= {dvd_i[DW-2:0], 1'b0};
            den_reg  <= den_i;
            rem_reg  <= rem_next;
            quo_reg  <= {quo_i[DW-2:0], ge};
            side_reg <= side_i;
        end
    end

    assign vld_o  = vld_reg;
    assign dvd_o  = dvd_reg;
    assign den_o  = den_reg;
    assign rem_o  = rem_reg;
    assign quo_o  = quo_reg;
    assign side_o = side_reg;

endmodule

// ===== src/rotation_matrix_to_quaternion_core.sv =====
// Top level: rotation matrix (Q1.FRAC_BITS) to unit quaternion, fully pipelined.
//
// Input channel: in_valid / in_stall carry one request of nine matrix elements.
// Output channel: out_valid / out_stall carry qx, qy, qz, qw and degenerate.
// A request is taken on a rising edge with valid high and stall low.
// The pipeline is a setup stage, a chain of RW square root cells (RW = root
// width), a rounding stage, three parallel chains of DW divider cells (DW =
// dividend width) and an output register. One request per cycle is accepted
// while the pipeline is not frozen by a stall.
// When the receiver stalls with a result in the output register, the whole
// pipeline freezes and in_stall goes high until the result is taken.
// Reset clears all valid bits; no request is in flight afterwards.
// A nonpositive root argument sets each component to zero or a limit and raises
// degenerate; an out of range component saturates and raises degenerate.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  m00,
    input  logic signed [IN_W-1:0]  m01,
    input  logic signed [IN_W-1:0]  m02,
    input  logic signed [IN_W-1:0]  m10,
    input  logic signed [IN_W-1:0]  m11,
    input  logic signed [IN_W-1:0]  m12,
    input  logic signed [IN_W-1:0]  m20,
    input  logic signed [IN_W-1:0]  m21,
    input  logic signed [IN_W-1:0]  m22,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [Q_W-1:0]   qx,
    output logic signed [Q_W-1:0]   qy,
    output logic signed [Q_W-1:0]   qz,
    output logic signed [Q_W-1:0]   qw,
    output logic                    degenerate
);

    localparam int ARGW  = ((FRAC_BITS + 1 > IN_W + 2) ? FRAC_BITS + 1 : IN_W + 2) + 2;
    localparam int VW    = ARGW - 1 + FRAC_BITS;
    localparam int SW    = VW + (VW % 2);
    localparam int RW    = SW / 2;
    localparam int DENW  = RW + 2;
    localparam int DW0   = NUM_W + FRAC_BITS + 1;
    localparam int DW    = ((DW0 > RW + 2) ? DW0 : RW + 2) + 1;
    localparam int SSIDE = 3 * NUM_W + 4;
    localparam int S0    = 2 + 1 + 1 + 1 + Q_W + 2;

    logic en;
    logic out_vld_reg;

    assign en       = !(out_vld_reg && out_stall);
    assign in_stall = !en;

    // setup stage
    logic signed [IN_W-1:0]  mm [0:2][0:2];
    logic signed [IN_W+1:0]  trace;
    logic signed [ARGW-1:0]  one;
    logic signed [ARGW-1:0]  arg;
    logic                    pos;
    logic                    nonpos;
    axis_t                   ai, aj, ak;
    logic signed [NUM_W-1:0] na, nb, nc;
    logic [SW-1:0]           rad;

    always_comb
    begin
        mm[0][0] = m00; mm[0][1] = m01; mm[0][2] = m02;
        mm[1][0] = m10; mm[1][1] = m11; mm[1][2] = m12;
        mm[2][0] = m20; mm[2][1] = m21; mm[2][2] = m22;
        trace = (IN_W+2)'(m00) + (IN_W+2)'(m11) + (IN_W+2)'(m22);
        one   = ARGW'(1) <<< FRAC_BITS;
        pos   = trace > 0;
        ai = AXIS_X;
        if (m11 > m00)
        begin
            ai = AXIS_Y;
        end
        if (m22 > mm[ai][ai])
        begin
            ai = AXIS_Z;
        end
        aj = next_axis(ai);
        ak = next_axis(aj);
        if (pos)
        begin
            arg = ARGW'(trace) + one;
            na  = NUM_W'(m12) - NUM_W'(m21);
            nb  = NUM_W'(m20) - NUM_W'(m02);
            nc  = NUM_W'(m01) - NUM_W'(m10);
        end
        else
        begin
            arg = ARGW'(mm[ai][ai]) - ARGW'(mm[aj][aj]) - ARGW'(mm[ak][ak]) + one;
            na  = NUM_W'(mm[aj][ak]) - NUM_W'(mm[ak][aj]);
            nb  = NUM_W'(mm[aj][ai]) + NUM_W'(mm[ai][aj]);
            nc  = NUM_W'(mm[ak][ai]) + NUM_W'(mm[ai][ak]);
        end
        nonpos = !pos && (arg <= 0);
        // radicand is arg scaled by one, zero padded on top to an even width
        rad    = nonpos ? '0 : (SW'(arg[ARGW-2:0]) << FRAC_BITS);
    end

    logic             st0_vld_reg;
    logic [SW-1:0]    st0_rad_reg;
    logic [SSIDE-1:0] st0_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st0_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            st0_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st0_rad_reg  <= rad;
            st0_side_reg <= {ai, pos, nonpos, na, nb, nc};
        end
    end

    // square root chain
    logic             sq_vld  [0:RW];
    logic [SW-1:0]    sq_rad  [0:RW];
    logic [RW+1:0]    sq_rem  [0:RW];
    logic [RW-1:0]    sq_root [0:RW];
    logic [SSIDE-1:0] sq_side [0:RW];

    assign sq_vld[0]  = st0_vld_reg;
    assign sq_rad[0]  = st0_rad_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = st0_side_reg;

    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        rmq_sqrt_cell #(.SW(SW), .RW(RW), .SIDE(SSIDE)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_i  (sq_vld[g]),
            .rad_i  (sq_rad[g]),
            .rem_i  (sq_rem[g]),
            .root_i (sq_root[g]),
            .side_i (sq_side[g]),
            .vld_o  (sq_vld[g+1]),
            .rad_o  (sq_rad[g+1]),
            .rem_o  (sq_rem[g+1]),
            .root_o (sq_root[g+1]),
            .side_o (sq_side[g+1])
        );
    end

    // rounding stage: half root and dividends
    logic [RW-1:0]           root;
    logic [RW:0]             half;
    comp_t                   hcomp;
    axis_t                   s_ai;
    logic                    s_pos, s_nonpos;
    logic signed [NUM_W-1:0] s_num [0:2];
    logic [NUM_W-1:0]        mag   [0:2];
    logic [DW-1:0]           dvd   [0:2];

    always_comb
    begin
        root = sq_root[RW];
        {s_ai, s_pos, s_nonpos, s_num[0], s_num[1], s_num[2]} = sq_side[RW];
        half = ((RW+1)'(root) + (RW+1)'(1)) >> 1;
        hcomp.deg = half > (RW+1)'(Q_MAX);
        hcomp.val = hcomp.deg ? Q_MAX : half[Q_W-1:0];
        for (int n = 0; n < 3; n++)
        begin
            mag[n] = s_num[n][NUM_W-1] ? NUM_W'(-s_num[n]) : NUM_W'(s_num[n]);
            dvd[n] = (DW'(mag[n]) << (FRAC_BITS + 1)) + (DW'(root) << 1);
        end
    end

    logic            st1_vld_reg;
    logic [DENW-1:0] st1_den_reg;
    logic [DW-1:0]   st1_dvd_reg  [0:2];
    logic [1:0]      st1_sgn_reg  [0:2];
    logic [S0-3:0]   st1_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            st1_vld_reg <= sq_vld[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_den_reg <= {root, 2'b00};
            for (int n = 0; n < 3; n++)
            begin
                st1_dvd_reg[n] <= dvd[n];
                st1_sgn_reg[n] <= {s_num[n][NUM_W-1], s_num[n] == '0};
            end
            st1_ctl_reg <= {s_ai, s_pos, s_nonpos, hcomp};
        end
    end

    // three divider chains; lane 0 also carries control
    logic           dv_vld [0:2][0:DW];
    logic [DW-1:0]  dv_dvd [0:2][0:DW];
    logic [DENW-1:0] dv_den [0:2][0:DW];
    logic [DENW-1:0] dv_rem [0:2][0:DW];
    logic [DW-1:0]  dv_quo [0:2][0:DW];
    logic [S0-1:0]  dv_side0 [0:DW];
    logic [1:0]     dv_side1 [0:DW];
    logic [1:0]     dv_side2 [0:DW];

    for (genvar l = 0; l < 3; l++)
    begin : g_lane_in
        assign dv_vld[l][0] = st1_vld_reg;
        assign dv_dvd[l][0] = st1_dvd_reg[l];
        assign dv_den[l][0] = st1_den_reg;
        assign dv_rem[l][0] = '0;
        assign dv_quo[l][0] = '0;
    end
    assign dv_side0[0] = {st1_ctl_reg, st1_sgn_reg[0]};
    assign dv_side1[0] = st1_sgn_reg[1];
    assign dv_side2[0] = st1_sgn_reg[2];

    for (genvar g = 0; g < DW; g++)
    begin : g_div
        rmq_div_cell #(.DW(DW), .DENW(DENW), .SIDE(S0)) u_lane0 (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vld_i(dv_vld[0][g]), .dvd_i(dv_dvd[0][g]), .den_i(dv_den[0][g]),
            .rem_i(dv_rem[0][g]), .quo_i(dv_quo[0][g]), .side_i(dv_side0[g]),
            .vld_o(dv_vld[0][g+1]), .dvd_o(dv_dvd[0][g+1]), .den_o(dv_den[0][g+1]),
            .rem_o(dv_rem[0][g+1]), .quo_o(dv_quo[0][g+1]), .side_o(dv_side0[g+1])
        );
        rmq_div_cell #(.DW(DW), .DENW(DENW), .SIDE(2)) u_lane1 (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vld_i(dv_vld[1][g]), .dvd_i(dv_dvd[1][g]), .den_i(dv_den[1][g]),
            .rem_i(dv_rem[1][g]), .quo_i(dv_quo[1][g]), .side_i(dv_side1[g]),
            .vld_o(dv_vld[1][g+1]), .dvd_o(dv_dvd[1][g+1]), .den_o(dv_den[1][g+1]),
            .rem_o(dv_rem[1][g+1]), .quo_o(dv_quo[1][g+1]), .side_o(dv_side1[g+1])
        );
        rmq_div_cell #(.DW(DW), .DENW(DENW), .SIDE(2)) u_lane2 (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vld_i(dv_vld[2][g]), .dvd_i(dv_dvd[2][g]), .den_i(dv_den[2][g]),
            .rem_i(dv_rem[2][g]), .quo_i(dv_quo[2][g]), .side_i(dv_side2[g]),
            .vld_o(dv_vld[2][g+1]), .dvd_o(dv_dvd[2][g+1]), .den_o(dv_den[2][g+1]),
            .rem_o(dv_rem[2][g+1]), .quo_o(dv_quo[2][g+1]), .side_o(dv_side2[g+1])
        );
    end

    // sign, saturation and component placement
    function automatic comp_t finish(input logic [DW-1:0] q, input logic [1:0] sgn,
                                     input logic zroot);
        comp_t c;
        c.deg = 1'b0;
        if (zroot)
        begin
            c.deg = 1'b1;
            c.val = sgn[0] ? '0 : (sgn[1] ? Q_MIN : Q_MAX);
        end
        else if (sgn[1])
        begin
            if (q > DW'(32768))
            begin
                c.deg = 1'b1;
                c.val = Q_MIN;
            end
            else
            begin
                c.val = Q_W'(-q);
            end
        end
        else if (q > DW'(Q_MAX))
        begin
            c.deg = 1'b1;
            c.val = Q_MAX;
        end
        else
        begin
            c.val = q[Q_W-1:0];
        end
        return c;
    endfunction

    axis_t      f_ai;
    logic       f_pos, f_nonpos;
    comp_t      f_h, ra, rb, rc, f_hc;
    logic [1:0] f_sgn0;
    logic [Q_W-1:0] vx, vy, vz, vw;
    logic       vdeg;

    always_comb
    begin
        {f_ai, f_pos, f_nonpos, f_h, f_sgn0} = dv_side0[DW];
        ra = finish(dv_quo[0][DW], f_sgn0, f_nonpos);
        rb = finish(dv_quo[1][DW], dv_side1[DW], f_nonpos);
        rc = finish(dv_quo[2][DW], dv_side2[DW], f_nonpos);
        f_hc = f_nonpos ? comp_t'{deg: 1'b1, val: '0} : f_h;
        vdeg = ra.deg | rb.deg | rc.deg | f_hc.deg;
        if (f_pos)
        begin
            vx = ra.val; vy = rb.val; vz = rc.val; vw = f_hc.val;
        end
        else
        begin
            vw = ra.val;
            case (f_ai)
                AXIS_X:
                begin
                    vx = f_hc.val; vy = rb.val; vz = rc.val;
                end
                AXIS_Y:
                begin
                    vy = f_hc.val; vz = rb.val; vx = rc.val;
                end
                default:
                begin
                    vz = f_hc.val; vx = rb.val; vy = rc.val;
                end
            endcase
        end
    end

    logic [Q_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic           deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld[0][DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg  <= vx;
            qy_reg  <= vy;
            qz_reg  <= vz;
            qw_reg  <= vw;
            deg_reg <= vdeg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign qx         = qx_reg;
    assign qy         = qy_reg;
    assign qz         = qz_reg;
    assign qw         = qw_reg;
    assign degenerate = deg_reg;

endmodule
